@@ hw/rtl/tcgp_pkg.sv @@
package tcgp_pkg;

  // Default glyph count of the width store
  localparam int unsigned FontEntriesDefault = 256;

  // Command codes on the input channel
  localparam logic [1:0] CMD_CHAR   = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_SETPOS = 2'd2;
  localparam logic [1:0] CMD_HOME   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_CODE   = 3'd0;
  localparam logic [2:0] REG_LAST_CODE    = 3'd1;
  localparam logic [2:0] REG_FONT_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_GLYPH_STRIDE = 3'd3;
  localparam logic [2:0] REG_MONO_WIDTH   = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH = 3'd5;

  // Control characters
  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_CR  = 8'h0D;

  // Register reset values
  localparam logic [7:0] RST_FIRST_CODE   = 8'd32;
  localparam logic [7:0] RST_LAST_CODE    = 8'd127;
  localparam logic [7:0] RST_FONT_HEIGHT  = 8'd8;
  localparam logic [7:0] RST_GLYPH_STRIDE = 8'd9;
  localparam logic [7:0] RST_MONO_WIDTH   = 8'd0;
  localparam logic [7:0] RST_SCREEN_WIDTH = 8'd128;

endpackage

@@ hw/rtl/tcgp_if.sv @@
interface tcgp_in_if;
  import tcgp_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic       last_in_string;
  logic [7:0] glyph_width;
  logic [7:0] pos_x;
  logic [7:0] pos_y;

  modport source (output valid, command, char_code, last_in_string, glyph_width, pos_x, pos_y,
                  input ready);
  modport sink (input valid, command, char_code, last_in_string, glyph_width, pos_x, pos_y,
                output ready);
endinterface

interface tcgp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dest_x;
  logic [7:0]  dest_y;
  logic [7:0]  draw_width;
  logic [7:0]  draw_height;
  logic [15:0] glyph_offset;

  modport source (output valid, dest_x, dest_y, draw_width, draw_height, glyph_offset,
                  input ready);
  modport sink (input valid, dest_x, dest_y, draw_width, draw_height, glyph_offset,
                output ready);
endinterface

@@ hw/rtl/tcgp_width_store.sv @@
module tcgp_width_store
  import tcgp_pkg::*;
#(
  parameter int unsigned FONT_ENTRIES = FontEntriesDefault,
  localparam int unsigned AW = $clog2(FONT_ENTRIES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [FONT_ENTRIES];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/text_cursor_glyph_placer_unit.sv @@
// Text cursor glyph placer: takes one command beat per cycle while ready, keeps a text
// cursor and places one blit descriptor per character in the font but NUL, CR and LF,
// skipping the rest of a string after a NUL. When an input beat is taken, the glyph
// width store (a synchronous memory of FONT_ENTRIES bytes) is read and stage 1 takes the
// beat; when stage 1 advances, the cursor is updated and the output register is loaded.
// Sustained rate is one item per cycle while the output is taken; input ready drops only
// while a result waits in the output register and another one is due behind it. The
// width store has no reset; entries must be loaded before use. Configuration is written
// through cfg_we/cfg_index/cfg_data while the block is idle; the user must ensure this.
module text_cursor_glyph_placer_unit
  import tcgp_pkg::*;
#(
  parameter int unsigned FONT_ENTRIES = FontEntriesDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  tcgp_in_if.sink    in_ch,
  tcgp_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int unsigned AW = $clog2(FONT_ENTRIES);

  typedef enum logic [1:0] {
    KIND_GLYPH,
    KIND_NUL,
    KIND_CR,
    KIND_LF
  } kind_t;

  // Configuration registers
  logic [7:0] first_code_r, last_code_r, font_height_r;
  logic [7:0] glyph_stride_r, mono_width_r, screen_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r   <= RST_FIRST_CODE;
      last_code_r    <= RST_LAST_CODE;
      font_height_r  <= RST_FONT_HEIGHT;
      glyph_stride_r <= RST_GLYPH_STRIDE;
      mono_width_r   <= RST_MONO_WIDTH;
      screen_width_r <= RST_SCREEN_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_CODE:   first_code_r   <= cfg_data;
        REG_LAST_CODE:    last_code_r    <= cfg_data;
        REG_FONT_HEIGHT:  font_height_r  <= cfg_data;
        REG_GLYPH_STRIDE: glyph_stride_r <= cfg_data;
        REG_MONO_WIDTH:   mono_width_r   <= cfg_data;
        REG_SCREEN_WIDTH: screen_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: decode the beat and address the width store
  logic       in_take;
  logic [7:0] idx0;
  logic       ok0;
  kind_t      kind0;
  logic       load_ok0;

  assign in_take = in_ch.valid && in_ch.ready;
  assign idx0    = in_ch.char_code - first_code_r;
  assign ok0     = (in_ch.char_code >= first_code_r) && (in_ch.char_code <= last_code_r)
                   && ({1'b0, idx0} < 9'(FONT_ENTRIES));
  assign load_ok0 = {1'b0, in_ch.char_code} < 9'(FONT_ENTRIES);

  always_comb begin
    case (in_ch.char_code)
      CHR_NUL: kind0 = KIND_NUL;
      CHR_CR:  kind0 = KIND_CR;
      CHR_LF:  kind0 = KIND_LF;
      default: kind0 = KIND_GLYPH;
    endcase
  end

  logic [7:0] rd_width;

  tcgp_width_store #(.FONT_ENTRIES(FONT_ENTRIES)) u_store (
    .clk     (clk),
    .wr_en   (in_take && in_ch.command == CMD_LOAD && load_ok0),
    .wr_addr (in_ch.char_code[AW-1:0]),
    .wr_data (in_ch.glyph_width),
    .rd_en   (in_take && in_ch.command == CMD_CHAR && ok0),
    .rd_addr (idx0[AW-1:0]),
    .rd_data (rd_width)
  );

  // Stage 1 registers
  logic       s1_valid_r;
  logic [1:0] s1_cmd_r;
  kind_t      s1_kind_r;
  logic       s1_ok_r;
  logic [7:0] s1_idx_r;
  logic       s1_last_r;
  logic [7:0] s1_pos_x_r, s1_pos_y_r;

  // Cursor state
  logic [7:0] col_r, row_r, col_nxt, row_nxt;
  logic       cr_pend_r, cr_pend_nxt;
  logic       stopped_r, stopped_nxt;

  // Output register
  logic        out_valid_r;
  logic [7:0]  dest_x_r, dest_y_r, draw_width_r, draw_height_r;
  logic [15:0] offset_r;

  // Stage 1: place the glyph and move the cursor
  logic [7:0]  stored, w;
  logic        wrap;
  logic [7:0]  col_base, row_base;
  logic        s1_emit, s1_adv;
  logic [15:0] offset_nxt;

  assign stored   = s1_ok_r ? rd_width : 8'd0;
  assign w        = (mono_width_r != 8'd0) ? mono_width_r : stored;
  assign wrap     = ({1'b0, col_r} + {1'b0, w}) > {1'b0, screen_width_r};
  assign col_base = wrap ? 8'd0 : col_r;
  assign row_base = wrap ? row_r + font_height_r : row_r;
  assign offset_nxt = ({8'd0, s1_idx_r} * {8'd0, glyph_stride_r}) + 16'd1;

  assign s1_emit = s1_valid_r && s1_cmd_r == CMD_CHAR && !stopped_r
                   && s1_kind_r == KIND_GLYPH && s1_ok_r;
  assign s1_adv  = s1_valid_r && (!s1_emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    cr_pend_nxt = cr_pend_r;
    stopped_nxt = stopped_r;
    case (s1_cmd_r)
      CMD_SETPOS: begin
        col_nxt = s1_pos_x_r;
        row_nxt = s1_pos_y_r;
      end
      CMD_HOME: begin
        col_nxt = 8'd0;
        row_nxt = 8'd0;
      end
      CMD_CHAR: begin
        if (!stopped_r) begin
          case (s1_kind_r)
            KIND_NUL: stopped_nxt = 1'b1;
            KIND_CR: begin
              col_nxt     = 8'd0;
              row_nxt     = row_r + font_height_r;
              cr_pend_nxt = 1'b1;
            end
            KIND_LF: begin
              if (!cr_pend_r) begin
                col_nxt = 8'd0;
                row_nxt = row_r + font_height_r;
              end
              cr_pend_nxt = 1'b0;
            end
            default: begin
              cr_pend_nxt = 1'b0;
              col_nxt     = col_base + w + 8'd1;
              row_nxt     = row_base;
            end
          endcase
        end
        // End of string clears the pair flag and the skip
        if (s1_last_r) begin
          cr_pend_nxt = 1'b0;
          stopped_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      col_r       <= 8'd0;
      row_r       <= 8'd0;
      cr_pend_r   <= 1'b0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        cr_pend_r <= cr_pend_nxt;
        stopped_r <= stopped_nxt;
      end
      if (s1_adv && s1_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the beat for stage 1 and the result
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= in_ch.command;
      s1_kind_r  <= kind0;
      s1_ok_r    <= ok0;
      s1_idx_r   <= idx0;
      s1_last_r  <= in_ch.last_in_string;
      s1_pos_x_r <= in_ch.pos_x;
      s1_pos_y_r <= in_ch.pos_y;
    end
    if (s1_adv && s1_emit) begin
      dest_x_r      <= col_base;
      dest_y_r      <= row_base;
      draw_width_r  <= stored;
      draw_height_r <= font_height_r;
      offset_r      <= offset_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.dest_x       = dest_x_r;
  assign out_ch.dest_y       = dest_y_r;
  assign out_ch.draw_width   = draw_width_r;
  assign out_ch.draw_height  = draw_height_r;
  assign out_ch.glyph_offset = offset_r;

endmodule

@@ hw/rtl/tcgp_checker.sv @@
module tcgp_checker
  import tcgp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  dest_x,
  input logic [7:0]  dest_y,
  input logic [15:0] glyph_offset
);

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A fresh result follows an accepted input beat
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input beat");

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(dest_x) && $stable(dest_y) && $stable(glyph_offset)))
    else $error("stalled result changed");

endmodule

bind text_cursor_glyph_placer_unit tcgp_checker u_tcgp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .dest_x       (out_ch.dest_x),
  .dest_y       (out_ch.dest_y),
  .glyph_offset (out_ch.glyph_offset)
);

@@ tb/glyph_blit_monitor.sv @@
module glyph_blit_monitor
  import tcgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tcgp_in_if         in_mon,
  tcgp_out_if        out_mon,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         blits_due,
  output int         blit_mismatches
);

  typedef struct packed {
    logic [7:0]  dest_x;
    logic [7:0]  dest_y;
    logic [7:0]  draw_width;
    logic [7:0]  draw_height;
    logic [15:0] glyph_offset;
  } blit_t;

  // Local copy of the font registers
  logic [7:0] font_first;
  logic [7:0] font_last;
  logic [7:0] line_advance;
  logic [7:0] record_bytes;
  logic [7:0] mono_width;
  logic [7:0] screen_width;

  // Cursor state and glyph width table
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic       cr_seen;
  logic       skipping;
  logic [7:0] glyph_widths [FontEntriesDefault];

  blit_t blit_q [$];
  blit_t oldest;

  task automatic line_feed();
    cur_col = 8'd0;
    cur_row = cur_row + line_advance;
  endtask

  // Wrap if needed, queue a blit for glyphs in the font, then advance
  task automatic place_glyph(input logic [7:0] code);
    logic       hit;
    logic [7:0] idx;
    logic [7:0] stored;
    logic [7:0] adv;
    logic [8:0] reach;
    blit_t      b;
    hit    = (code >= font_first) && (code <= font_last);
    idx    = code - font_first;
    stored = hit ? glyph_widths[idx] : 8'd0;
    adv    = (mono_width != 8'd0) ? mono_width : stored;
    cr_seen = 1'b0;
    reach  = {1'b0, cur_col} + {1'b0, adv};
    if (reach > {1'b0, screen_width}) line_feed();
    if (hit) begin
      b.dest_x       = cur_col;
      b.dest_y       = cur_row;
      b.draw_width   = stored;
      b.draw_height  = line_advance;
      b.glyph_offset = 16'(idx) * 16'(record_bytes) + 16'd1;
      blit_q.push_back(b);
    end
    cur_col = cur_col + adv + 8'd1;
  endtask

  task automatic take_command();
    logic [7:0] code;
    code = in_mon.char_code;
    case (in_mon.command)
      CMD_LOAD: begin
        if (32'(code) < FontEntriesDefault) glyph_widths[code] = in_mon.glyph_width;
      end
      CMD_SETPOS: begin
        cur_col = in_mon.pos_x;
        cur_row = in_mon.pos_y;
      end
      CMD_HOME: begin
        cur_col = 8'd0;
        cur_row = 8'd0;
      end
      CMD_CHAR: begin
        if (!skipping) begin
          if (code == CHR_NUL) begin
            skipping = 1'b1;
          end else if (code == CHR_CR) begin
            line_feed();
            cr_seen = 1'b1;
          end else if (code == CHR_LF) begin
            // a CR just before already did the newline
            if (!cr_seen) line_feed();
            cr_seen = 1'b0;
          end else begin
            place_glyph(code);
          end
        end
        if (in_mon.last_in_string) begin
          cr_seen  = 1'b0;
          skipping = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      blit_mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      font_first      = RST_FIRST_CODE;
      font_last       = RST_LAST_CODE;
      line_advance    = RST_FONT_HEIGHT;
      record_bytes    = RST_GLYPH_STRIDE;
      mono_width      = RST_MONO_WIDTH;
      screen_width    = RST_SCREEN_WIDTH;
      cur_col         = 8'd0;
      cur_row         = 8'd0;
      cr_seen         = 1'b0;
      skipping        = 1'b0;
      blit_mismatches = 0;
      blit_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_CODE:   font_first   = cfg_data;
          REG_LAST_CODE:    font_last    = cfg_data;
          REG_FONT_HEIGHT:  line_advance = cfg_data;
          REG_GLYPH_STRIDE: record_bytes = cfg_data;
          REG_MONO_WIDTH:   mono_width   = cfg_data;
          REG_SCREEN_WIDTH: screen_width = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_command();
      // Compare each result beat with the oldest predicted blit
      if (out_mon.valid && out_mon.ready) begin
        if (blit_q.size() == 0) begin
          $display("%0t: blit expected none, got x %0d y %0d w %0d h %0d off %0d", $time,
                   out_mon.dest_x, out_mon.dest_y, out_mon.draw_width,
                   out_mon.draw_height, out_mon.glyph_offset);
          blit_mismatches++;
        end else begin
          oldest = blit_q.pop_front();
          check_field("dest_x", 16'(oldest.dest_x), 16'(out_mon.dest_x));
          check_field("dest_y", 16'(oldest.dest_y), 16'(out_mon.dest_y));
          check_field("draw_width", 16'(oldest.draw_width), 16'(out_mon.draw_width));
          check_field("draw_height", 16'(oldest.draw_height), 16'(out_mon.draw_height));
          check_field("glyph_offset", oldest.glyph_offset, out_mon.glyph_offset);
        end
      end
    end
    blits_due <= blit_q.size();
  end

endmodule

@@ tb/tb_text_cursor_glyph_placer_unit.sv @@
module tb_text_cursor_glyph_placer_unit;
  import tcgp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  tcgp_in_if  in_ch ();
  tcgp_out_if out_ch ();

  int          blits_due;
  int          blit_mismatches;
  int          cycles = 0;
  int          items_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        rx_hold;
  logic        hold_go;
  logic [7:0]  cur_first = RST_FIRST_CODE;
  logic [7:0]  cur_last = RST_LAST_CODE;
  bit          width_loaded [256];

  text_cursor_glyph_placer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_blit_monitor u_blit_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .blits_due       (blits_due),
    .blit_mismatches (blit_mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up after a generous number of cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    rx_hold <= 1'b0;
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Offer one beat, with random gaps before it, and hold it until taken
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] code,
                           input logic last, input logic [7:0] gw,
                           input logic [7:0] px, input logic [7:0] py);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.char_code      <= code;
    in_ch.last_in_string <= last;
    in_ch.glyph_width    <= gw;
    in_ch.pos_x          <= px;
    in_ch.pos_y          <= py;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_LOAD) width_loaded[code] = 1'b1;
  endtask

  function automatic logic [7:0] pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(12));
    if (r < 90) return 8'($urandom_range(40));
    return 8'($urandom_range(255));
  endfunction

  // Send a character; load its width first if the glyph entry is still blank
  task automatic send_char(input logic [7:0] code, input logic last);
    logic [7:0] idx;
    idx = code - cur_first;
    if (code >= cur_first && code <= cur_last && !width_loaded[idx]) begin
      send_beat(CMD_LOAD, idx, 1'($urandom_range(1)), pick_width(),
                8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    send_beat(CMD_CHAR, code, last, 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 72 && cur_first <= cur_last) return 8'($urandom_range(cur_last, cur_first));
    if (r < 80) return CHR_CR;
    if (r < 87) return CHR_LF;
    if (r < 89) return CHR_NUL;
    return 8'($urandom_range(255));
  endfunction

  // Drop valid and wait until every predicted blit has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (blits_due != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_font_regs(input logic [7:0] fc, input logic [7:0] lc,
                                 input logic [7:0] fh, input logic [7:0] gs,
                                 input logic [7:0] mw, input logic [7:0] sw);
    logic [2:0] regs [6];
    logic [7:0] vals [6];
    regs = '{REG_FIRST_CODE, REG_LAST_CODE, REG_FONT_HEIGHT,
             REG_GLYPH_STRIDE, REG_MONO_WIDTH, REG_SCREEN_WIDTH};
    vals = '{fc, lc, fh, gs, mw, sw};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_first = fc;
    cur_last  = lc;
  endtask

  task automatic apply_random_font();
    logic [7:0] fc;
    fc = 8'($urandom_range(160));
    apply_font_regs(fc, 8'($urandom_range(255, fc)), 8'($urandom_range(255)),
                    8'($urandom_range(255, 1)),
                    $urandom_range(1) ? 8'($urandom_range(30, 1)) : 8'd0,
                    8'($urandom_range(255, 1)));
  endtask

  // Mostly strings of printable codes; some loads, moves and raw noise
  task automatic run_mix(input int target);
    int unsigned r;
    int unsigned len;
    logic [1:0]  cmd;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(12, 1);
        for (int j = 0; j < len; j++) send_char(pick_code(), j == len - 1);
      end else if (r < 80) begin
        send_beat(CMD_LOAD, cur_first <= cur_last ?
                    8'($urandom_range(cur_last - cur_first)) : 8'($urandom_range(255)),
                  1'($urandom_range(1)), pick_width(),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 85) begin
        send_beat(CMD_SETPOS, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 88) begin
        send_beat(CMD_HOME, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        cmd = 2'($urandom_range(3));
        if (cmd == CMD_CHAR) begin
          send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          send_beat(cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_CHAR;
    in_ch.char_code      <= 8'd0;
    in_ch.last_in_string <= 1'b0;
    in_ch.glyph_width    <= 8'd0;
    in_ch.pos_x          <= 8'd0;
    in_ch.pos_y          <= 8'd0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_FIRST_CODE;
    cfg_data             <= 8'd0;
    hold_go              <= 1'b0;
    rst_n                <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats on the reset font: edges of the font, wrap, CR/LF, NUL skip
    tx_idle_pct = 11;
    rx_idle_pct = 73;
    send_beat(CMD_LOAD, 8'd33, 1'b0, 8'd5, 8'd0, 8'd0);
    send_beat(CMD_LOAD, 8'd95, 1'b1, 8'd255, 8'hFF, 8'hFF);
    send_beat(CMD_LOAD, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_LOAD, 8'd255, 1'b1, 8'd7, 8'hFF, 8'hFF);
    send_char(8'd65, 1'b0);
    send_char(RST_FIRST_CODE, 1'b0);
    send_char(RST_LAST_CODE, 1'b0);
    send_char(RST_FIRST_CODE - 8'd1, 1'b0);
    send_char(RST_LAST_CODE + 8'd1, 1'b0);
    send_char(CHR_CR, 1'b0);
    send_char(CHR_LF, 1'b0);
    send_char(CHR_LF, 1'b0);
    send_char(8'd65, 1'b1);
    send_char(CHR_CR, 1'b1);
    send_char(CHR_LF, 1'b0);
    send_char(CHR_NUL, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(8'd65, 1'b1);
    send_char(8'd65, 1'b0);
    send_beat(CMD_SETPOS, 8'd0, 1'b0, 8'd0, 8'd255, 8'd255);
    send_char(8'd65, 1'b0);
    send_beat(CMD_SETPOS, 8'hFF, 1'b1, 8'hFF, 8'd123, 8'd0);
    send_char(8'd65, 1'b1);
    send_beat(CMD_HOME, 8'hFF, 1'b1, 8'hFF, 8'hAA, 8'h55);
    send_char(8'd255, 1'b1);

    // Sender busy, receiver sparse
    wait_idle();
    apply_font_regs(RST_FIRST_CODE, RST_LAST_CODE, RST_FONT_HEIGHT,
                    RST_GLYPH_STRIDE, RST_MONO_WIDTH, RST_SCREEN_WIDTH);
    run_mix(230);
    wait_idle();
    apply_font_regs(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
    run_mix(430);

    // Sender sparse, receiver busy
    wait_idle();
    tx_idle_pct = 73;
    rx_idle_pct = 11;
    apply_font_regs(8'd65, 8'd90, 8'd16, 8'd1, 8'd6, 8'd100);
    run_mix(630);
    wait_idle();
    apply_font_regs(8'd255, 8'd255, 8'd0, 8'd200, 8'd255, 8'd1);
    run_mix(780);

    // Full rate both sides; hold the result side off to fill the block
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_random_font();
    hold_go <= 1'b1;
    run_mix(1000);
    wait_idle();
    apply_font_regs(8'd200, 8'd100, 8'd12, 8'd3, 8'd0, 8'd64);
    run_mix(1080);
    wait_idle();
    apply_random_font();
    run_mix(1400);

    wait_idle();
    if (blit_mismatches == 0 && blits_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tcgp_pkg.sv
hw/rtl/tcgp_if.sv
hw/rtl/tcgp_width_store.sv
hw/rtl/text_cursor_glyph_placer_unit.sv
hw/rtl/tcgp_checker.sv
tb/glyph_blit_monitor.sv
tb/tb_text_cursor_glyph_placer_unit.sv
